// File: rtl/hid_keyboard_line_editor_assert.svh
// assertion macros used by the line editor checker
`ifndef HID_KEYBOARD_LINE_EDITOR_ASSERT_SVH
`define HID_KEYBOARD_LINE_EDITOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HKLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hkle assertion failed");

// next-cycle implication, checked outside reset
`define HKLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hkle assertion failed");

`endif

// File: rtl/hkle_pkg.sv
// shared types, constants and keycode decode for the keyboard line editor
package hkle_pkg;

   localparam int LINE_COLUMNS = 62;
   localparam int KEY_SLOTS    = 6;

   localparam int COL_W  = $clog2(LINE_COLUMNS + 1);
   localparam int SLOT_W = $clog2(KEY_SLOTS + 1);
   localparam int KEY_W  = 8;
   localparam int CHAR_W = 7;
   localparam int POS_W  = 6;
   localparam int KIND_W = 3;

   // special keycodes
   localparam logic [KEY_W-1:0] KC_ENTER     = 8'h28;
   localparam logic [KEY_W-1:0] KC_BACKSPACE = 8'h2A;
   localparam logic [KEY_W-1:0] KC_RIGHT     = 8'h4F;
   localparam logic [KEY_W-1:0] KC_LEFT      = 8'h50;
   localparam logic [KEY_W-1:0] SHIFT_MASK   = 8'h22;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT,
      KIND_BACKSPACE,
      KIND_LEFT,
      KIND_RIGHT,
      KIND_ENTER,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [1:0] {
      LINE_HOLD,
      LINE_INSERT,
      LINE_DELETE
   } line_cmd_type;

   // edit command broadcast to every line cell
   typedef struct packed {
      line_cmd_type             cmd;
      logic [COL_W-1:0]         cursor;
      logic [COL_W-1:0]         count;
      logic [CHAR_W-1:0]        ch;
   } line_ctl_type;

   // control broadcast to every key cell
   typedef struct packed {
      logic load;
      logic shift;
      logic commit;
   } key_ctl_type;

   // boot keyboard keycode to ascii, zero when unmapped
   function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] kc,
                                                      input logic shift);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      if (kc >= 8'h04 && kc <= 8'h1D) begin
         ch = shift ? CHAR_W'(kc + 8'h3D) : CHAR_W'(kc + 8'h5D);
      end else begin
         case (kc)
            8'h1E: ch = shift ? 7'h21 : 7'h31;
            8'h1F: ch = shift ? 7'h40 : 7'h32;
            8'h20: ch = shift ? 7'h23 : 7'h33;
            8'h21: ch = shift ? 7'h24 : 7'h34;
            8'h22: ch = shift ? 7'h25 : 7'h35;
            8'h23: ch = shift ? 7'h5E : 7'h36;
            8'h24: ch = shift ? 7'h26 : 7'h37;
            8'h25: ch = shift ? 7'h2A : 7'h38;
            8'h26: ch = shift ? 7'h28 : 7'h39;
            8'h27: ch = shift ? 7'h29 : 7'h30;
            8'h2C: ch = 7'h20;
            8'h2D: ch = shift ? 7'h5F : 7'h2D;
            8'h2E: ch = shift ? 7'h2B : 7'h3D;
            8'h2F: ch = shift ? 7'h7B : 7'h5B;
            8'h30: ch = shift ? 7'h7D : 7'h5D;
            8'h31: ch = shift ? 7'h7C : 7'h5C;
            8'h33: ch = shift ? 7'h3A : 7'h3B;
            8'h34: ch = shift ? 7'h22 : 7'h27;
            8'h35: ch = shift ? 7'h7E : 7'h60;
            8'h36: ch = shift ? 7'h3C : 7'h2C;
            8'h37: ch = shift ? 7'h3E : 7'h2E;
            8'h38: ch = shift ? 7'h3F : 7'h2F;
            default: ch = '0;
         endcase
      end
      return ch;
   endfunction

endpackage

// File: rtl/hid_keyboard_line_editor.sv
// keyboard line editor top level: key slot chain, line cell chain and result sequencer
//
// req channel takes one boot keyboard report (tuser = 0) or a clear request
// (tuser = 1). For a report the key slots enter a row of cells that rotates
// one slot per cycle while not paused; the head slot is checked against the
// previous report's keys and decoded, and each new key yields one edit of the
// line buffer, itself a row of column cells that shift on insert and backspace.
// rsp channel gives one result per decoded key, tlast on the final one; a
// report without new keys gives no result, a clear gives exactly one.
// A result is held back by one decoded key in a pending register, so that
// tlast is known, until the next decoded key or the closing flush state.
// req_tready is high only while no request is in work.
// Reset (synchronous) clears previous keys, line, cursor and both channels.
// A stalled rsp side holds the output register; the key chain pauses while
// a held-back result cannot move on, and resumes with no loss.
module hid_keyboard_line_editor (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // modifier, key_slot_0 .. key_slot_5
   input  logic        req_tuser,   // op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // char_code, edit_position, line_length,
                                    // cursor_position, changed, zero pad
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast    // last
);
   import hkle_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  step_ff, step_in;
   logic               shift_ff, shift_in;
   logic [COL_W-1:0]   count_ff, count_in;
   logic [COL_W-1:0]   cursor_ff, cursor_in;

   // held-back result
   logic               pend_valid_ff, pend_valid_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic [COL_W-1:0]   pend_before_ff, pend_before_in;
   logic [COL_W-1:0]   pend_count_ff, pend_count_in;
   logic [COL_W-1:0]   pend_cursor_ff, pend_cursor_in;
   logic               pend_changed_ff, pend_changed_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [COL_W-1:0]   rsp_before_ff, rsp_before_in;
   logic [COL_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [COL_W-1:0]   rsp_cursor_ff, rsp_cursor_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               out_free;
   logic               move;
   logic               last_step;

   key_ctl_type        key_ctl;
   line_ctl_type       line_ctl;
   logic [KEY_W-1:0]   key_q  [KEY_SLOTS];
   logic [KEY_W-1:0]   prev_q [KEY_SLOTS];
   logic [KEY_W-1:0]   slot_in [KEY_SLOTS];
   logic [CHAR_W-1:0]  char_q [LINE_COLUMNS];

   // head slot decode
   logic [KEY_W-1:0]   head;
   logic               held;
   logic [CHAR_W-1:0]  map_ch;
   logic               fires;
   kind_type           ev_kind;
   logic [CHAR_W-1:0]  ev_char;
   logic [COL_W-1:0]   ev_count;
   logic [COL_W-1:0]   ev_cursor;
   logic               ev_changed;
   line_cmd_type       ev_cmd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = (state_ff == ST_RUN) && (!pend_valid_ff || out_free);
   assign last_step  = (step_ff == SLOT_W'(KEY_SLOTS - 1));

   // unpack report slots
   always_comb begin
      for (int s = 0; s < KEY_SLOTS; s++) begin
         slot_in[s] = req_tdata[KEY_W*(s+1) +: KEY_W];
      end
   end

   // key slot chain, rotating toward cell zero
   assign key_ctl.load   = accept && !req_tuser;
   assign key_ctl.shift  = move;
   assign key_ctl.commit = move && last_step;

   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_key
      hkle_key_cell u_key_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (key_ctl),
         .load_key  (slot_in[i]),
         .shift_key (key_q[(i + 1) % KEY_SLOTS]),
         .key       (key_q[i]),
         .prev_key  (prev_q[i])
      );
   end

   // line buffer chain
   assign line_ctl.cmd    = (move && fires) ? ev_cmd : LINE_HOLD;
   assign line_ctl.cursor = cursor_ff;
   assign line_ctl.count  = count_ff;
   assign line_ctl.ch     = ev_char;

   for (genvar j = 0; j < LINE_COLUMNS; j++) begin : g_line
      logic [CHAR_W-1:0] left_char;
      logic [CHAR_W-1:0] right_char;
      if (j == 0) begin : g_first
         assign left_char = '0;
      end else begin : g_inner_l
         assign left_char = char_q[j-1];
      end
      if (j == LINE_COLUMNS - 1) begin : g_final
         assign right_char = '0;
      end else begin : g_inner_r
         assign right_char = char_q[j+1];
      end
      hkle_line_cell u_line_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (line_ctl),
         .index      (COL_W'(j)),
         .left_char  (left_char),
         .right_char (right_char),
         .cell_char  (char_q[j])
      );
   end

   // key-down edge detection and edit decode for the head slot
   always_comb begin
      head = key_q[0];
      held = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         if (prev_q[k] == head) begin
            held = 1'b1;
         end
      end
      map_ch     = key_to_char(head, shift_ff);
      ev_kind    = KIND_INSERT;
      ev_char    = '0;
      ev_count   = count_ff;
      ev_cursor  = cursor_ff;
      ev_changed = 1'b0;
      ev_cmd     = LINE_HOLD;
      fires      = (head != '0) && !held;
      case (head)
         KC_BACKSPACE: begin
            ev_kind = KIND_BACKSPACE;
            if (cursor_ff != '0) begin
               ev_cursor  = cursor_ff - COL_W'(1);
               ev_count   = count_ff - COL_W'(1);
               ev_changed = 1'b1;
               ev_cmd     = LINE_DELETE;
            end
         end
         KC_LEFT: begin
            ev_kind = KIND_LEFT;
            if (cursor_ff != '0) begin
               ev_cursor  = cursor_ff - COL_W'(1);
               ev_changed = 1'b1;
            end
         end
         KC_RIGHT: begin
            ev_kind = KIND_RIGHT;
            if (cursor_ff < count_ff) begin
               ev_cursor  = cursor_ff + COL_W'(1);
               ev_changed = 1'b1;
            end
         end
         KC_ENTER: begin
            ev_kind    = KIND_ENTER;
            ev_changed = (count_ff != '0) || (cursor_ff != '0);
            ev_count   = '0;
            ev_cursor  = '0;
         end
         default: begin
            ev_kind = KIND_INSERT;
            ev_char = map_ch;
            fires   = fires && (map_ch != '0);
            if (count_ff < COL_W'(LINE_COLUMNS)) begin
               ev_count   = count_ff + COL_W'(1);
               ev_cursor  = cursor_ff + COL_W'(1);
               ev_changed = 1'b1;
               ev_cmd     = LINE_INSERT;
            end
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      shift_in        = shift_ff;
      count_in        = count_ff;
      cursor_in       = cursor_ff;
      pend_valid_in   = pend_valid_ff;
      pend_kind_in    = pend_kind_ff;
      pend_char_in    = pend_char_ff;
      pend_before_in  = pend_before_ff;
      pend_count_in   = pend_count_ff;
      pend_cursor_in  = pend_cursor_ff;
      pend_changed_in = pend_changed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_before_in   = rsp_before_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_last_in     = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  pend_valid_in   = 1'b1;
                  pend_kind_in    = KIND_CLEAR;
                  pend_char_in    = '0;
                  pend_before_in  = cursor_ff;
                  pend_count_in   = '0;
                  pend_cursor_in  = '0;
                  pend_changed_in = (count_ff != '0) || (cursor_ff != '0);
                  count_in        = '0;
                  cursor_in       = '0;
                  state_in        = ST_FLUSH;
               end else begin
                  shift_in = |(req_tdata[KEY_W-1:0] & SHIFT_MASK);
                  step_in  = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (move) begin
               if (fires) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = pend_kind_ff;
                     rsp_char_in    = pend_char_ff;
                     rsp_before_in  = pend_before_ff;
                     rsp_count_in   = pend_count_ff;
                     rsp_cursor_in  = pend_cursor_ff;
                     rsp_changed_in = pend_changed_ff;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_kind_in    = ev_kind;
                  pend_char_in    = ev_char;
                  pend_before_in  = cursor_ff;
                  pend_count_in   = ev_count;
                  pend_cursor_in  = ev_cursor;
                  pend_changed_in = ev_changed;
                  count_in        = ev_count;
                  cursor_in       = ev_cursor;
               end
               step_in = step_ff + SLOT_W'(1);
               if (last_step) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = pend_kind_ff;
               rsp_char_in    = pend_char_ff;
               rsp_before_in  = pend_before_ff;
               rsp_count_in   = pend_count_ff;
               rsp_cursor_in  = pend_cursor_ff;
               rsp_changed_in = pend_changed_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      step_ff         <= step_in;
      shift_ff        <= shift_in;
      pend_kind_ff    <= pend_kind_in;
      pend_char_ff    <= pend_char_in;
      pend_before_ff  <= pend_before_in;
      pend_count_ff   <= pend_count_in;
      pend_cursor_ff  <= pend_cursor_in;
      pend_changed_ff <= pend_changed_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_before_ff   <= rsp_before_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_changed_ff  <= rsp_changed_in;
      rsp_last_ff     <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cursor_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_changed_ff,
                        POS_W'(rsp_cursor_ff),
                        POS_W'(rsp_count_ff),
                        POS_W'(rsp_before_ff),
                        rsp_char_ff};

endmodule

// File: rtl/hkle_key_cell.sv
// one key slot cell: current report key in a rotating chain plus the previous key
module hkle_key_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  hkle_pkg::key_ctl_type     ctl,
   input  logic [hkle_pkg::KEY_W-1:0] load_key,
   input  logic [hkle_pkg::KEY_W-1:0] shift_key,
   output logic [hkle_pkg::KEY_W-1:0] key,
   output logic [hkle_pkg::KEY_W-1:0] prev_key
);
   import hkle_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] prev_ff, prev_in;

   // load from the request, or take the neighbor's key
   always_comb begin
      key_in  = key_ff;
      if (ctl.load) begin
         key_in = load_key;
      end else if (ctl.shift) begin
         key_in = shift_key;
      end
      prev_in = ctl.commit ? key_in : prev_ff;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   assign key      = key_ff;
   assign prev_key = prev_ff;

endmodule

// File: rtl/hkle_line_cell.sv
// one column of the line buffer, shifting with its neighbors on insert and delete
module hkle_line_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  hkle_pkg::line_ctl_type      ctl,
   input  logic [hkle_pkg::COL_W-1:0]  index,
   input  logic [hkle_pkg::CHAR_W-1:0] left_char,
   input  logic [hkle_pkg::CHAR_W-1:0] right_char,
   output logic [hkle_pkg::CHAR_W-1:0] cell_char
);
   import hkle_pkg::*;

   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W:0]    index_next;

   assign index_next = {1'b0, index} + (COL_W + 1)'(1);

   // pick the new column contents for the broadcast edit
   always_comb begin
      char_in = char_ff;
      case (ctl.cmd)
         LINE_INSERT: begin
            if (index == ctl.cursor) begin
               char_in = ctl.ch;
            end else if (index > ctl.cursor && index <= ctl.count) begin
               char_in = left_char;
            end
         end
         LINE_DELETE: begin
            if (index_next >= {1'b0, ctl.cursor} && index_next < {1'b0, ctl.count}) begin
               char_in = right_char;
            end
         end
         default: char_in = char_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign cell_char = char_ff;

endmodule

// File: rtl/hkle_checker.sv
// port-level checker for the keyboard line editor and its bind
`include "hid_keyboard_line_editor_assert.svh"

module hkle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import hkle_pkg::*;

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != '0 || req_tuser);

   // a result waits until taken
   `HKLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // cursor never beyond the end of the line
   `HKLE_ASSERT_IMPL(a_cursor_in_line, clock, reset, rsp_tvalid, rsp_tdata[24:19] <= rsp_tdata[18:13])

   // only insert results carry a character
   `HKLE_ASSERT_IMPL(a_char_only_insert, clock, reset, rsp_tvalid && rsp_tuser != KIND_INSERT, rsp_tdata[6:0] == 7'd0)

   // clear always leaves an empty line and closes its request
   `HKLE_ASSERT_IMPL(a_clear_empty, clock, reset, rsp_tvalid && rsp_tuser == KIND_CLEAR, rsp_tlast && rsp_tdata[24:13] == 12'd0)

   // a new request is never taken in the cycle right after a clear or a non-empty report
   `HKLE_ASSERT_NEXT(a_req_spacing, clock, reset, req_seen, !(req_tvalid && req_tready))

endmodule

bind hid_keyboard_line_editor hkle_checker u_hkle_checker (.*);
